// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the stream top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/c2u_pkg.sv =====
// ----------------------------------------------------------------------------
// c2u_pkg
// Types, character codes, code page table and UTF-8 encoder of the transcoder.
// ----------------------------------------------------------------------------
package c2u_pkg;

	// Control characters that steer the stream
	localparam logic [7:0] CHR_NUL = 8'h00;
	localparam logic [7:0] CHR_LF  = 8'h0A;
	localparam logic [7:0] CHR_CR  = 8'h0D;

	// UTF-8 lead and continuation marks
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [5:0] UTF8_MASK  = 6'h3F;

	// Queue between classifier and emitter
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Maximum bytes one input word produces
	localparam int MAX_OUT = 4;
	localparam int IDX_W   = $clog2(MAX_OUT);

	// Code points for bytes 0x80-0x9F; unassigned slots give the replacement char
	localparam logic [15:0] HI_MAP [32] = '{
		16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
		16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
	};

	// Class of one input byte
	typedef enum logic [1:0] {
		CLS_TEXT,
		CLS_NUL,
		CLS_LF,
		CLS_CR
	} c2u_cls_t;

	// One queued group of output bytes caused by one input word
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] data;
		logic [IDX_W-1:0]        last_idx;
		logic                    has_data;
		logic                    text_end;
	} c2u_entry_t;

	// Queue status seen by the front, the back and the top level
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} c2u_qstat_t;

	// Encoded UTF-8 sequence of one code point
	typedef struct packed {
		logic [2:0][7:0] b;
		logic [1:0]      len;
	} c2u_utf8_t;

	function automatic c2u_utf8_t utf8_enc(input logic [15:0] cp);
		c2u_utf8_t r;
		r = '0;
		if (cp < 16'h0080) begin
			r.b[0] = cp[7:0];
			r.len  = 2'd1;
		end else if (cp < 16'h0800) begin
			r.b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			r.b[1] = UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK};
			r.len  = 2'd2;
		end else begin
			r.b[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
			r.b[1] = UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK};
			r.b[2] = UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK};
			r.len  = 2'd3;
		end
		return r;
	endfunction

endpackage

// ===== sv/c2u_in_if.sv =====
// ----------------------------------------------------------------------------
// c2u_in_if
// Input word channel: one code page byte and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface c2u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== sv/c2u_out_if.sv =====
// ----------------------------------------------------------------------------
// c2u_out_if
// Output word channel: one UTF-8 byte with its run and text end flags.
// ----------------------------------------------------------------------------
interface c2u_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       text_end;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output text_end, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input run_last,
		input text_end, output ready);
endinterface

// ===== sv/c2u_front.sv =====
// ----------------------------------------------------------------------------
// c2u_front
// Classify input words, track the held CR and NUL stop, and build the byte
// group that each word produces.
// ----------------------------------------------------------------------------
module c2u_front
	import c2u_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	c2u_in_if.sink         rx,
	input  c2u_qstat_t     qstat,
	output logic           push,
	output c2u_entry_t     entry
);

	logic        held_cr_q;
	logic        stopped_q;
	logic        held_cr_d;
	logic        stopped_d;
	logic        accept;
	c2u_cls_t    cls;
	logic [15:0] cp;
	c2u_utf8_t   enc;
	logic [IDX_W:0] n;

	assign rx.ready = !qstat.full;
	assign accept   = rx.valid && rx.ready;

	// Classify the incoming byte
	always_comb begin
		case (rx.in_byte) inside
			CHR_NUL: cls = CLS_NUL;
			CHR_LF:  cls = CLS_LF;
			CHR_CR:  cls = CLS_CR;
			default: cls = CLS_TEXT;
		endcase
	end

	// Map to a code point and encode it
	always_comb begin
		if (rx.in_byte[7:5] == 3'b100) begin
			cp = HI_MAP[rx.in_byte[4:0]];
		end else begin
			cp = {8'h00, rx.in_byte};
		end
		enc = utf8_enc(cp);
	end

	// Build the byte group and next state
	always_comb begin
		entry     = '0;
		n         = '0;
		held_cr_d = held_cr_q;
		stopped_d = stopped_q;
		if (!stopped_q) begin
			case (cls)
				CLS_NUL: begin
					if (held_cr_q) begin
						entry.data[n[IDX_W-1:0]] = CHR_CR;
						n = n + 1'b1;
					end
					held_cr_d = 1'b0;
					stopped_d = 1'b1;
				end
				CLS_LF: begin
					held_cr_d = 1'b0;
					entry.data[n[IDX_W-1:0]] = CHR_LF;
					n = n + 1'b1;
				end
				CLS_CR: begin
					if (held_cr_q) begin
						entry.data[n[IDX_W-1:0]] = CHR_CR;
						n = n + 1'b1;
					end
					held_cr_d = 1'b1;
				end
				default: begin
					if (held_cr_q) begin
						entry.data[n[IDX_W-1:0]] = CHR_CR;
						n = n + 1'b1;
					end
					held_cr_d = 1'b0;
					for (int i = 0; i < 3; i++) begin
						if (2'(i) < enc.len) begin
							entry.data[n[IDX_W-1:0]] = enc.b[i];
							n = n + 1'b1;
						end
					end
				end
			endcase
		end
		entry.has_data = 1'b1;
		// Flush at the end of the buffer; emit a bare marker if nothing else
		if (rx.last_byte) begin
			if (held_cr_d) begin
				entry.data[n[IDX_W-1:0]] = CHR_CR;
				n = n + 1'b1;
			end
			if (n == '0) begin
				entry.has_data = 1'b0;
				n = n + 1'b1;
			end
			entry.text_end = 1'b1;
			held_cr_d      = 1'b0;
			stopped_d      = 1'b0;
		end
		entry.last_idx = IDX_W'(n - 1'b1);
	end

	assign push = accept && (n != '0);

	// Advance stream state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cr_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			held_cr_q <= held_cr_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

// ===== sv/c2u_fifo.sv =====
// ----------------------------------------------------------------------------
// c2u_fifo
// Short queue of byte groups between the classifier and the emitter.
// ----------------------------------------------------------------------------
module c2u_fifo
	import c2u_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  c2u_entry_t  wdata,
	input  logic        pop,
	output c2u_entry_t  head,
	output c2u_qstat_t  qstat
);

	c2u_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign qstat.count = count_q;
	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/c2u_back.sv =====
// ----------------------------------------------------------------------------
// c2u_back
// Walk head group bytes to the output register, one per cycle unless tx stalls.
// ----------------------------------------------------------------------------
module c2u_back
	import c2u_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  c2u_entry_t  head,
	input  c2u_qstat_t  qstat,
	output logic        pop,
	c2u_out_if.source   tx
);

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             byte_valid_q;
	logic             run_last_q;
	logic             text_end_q;
	logic             advance;
	logic             load;
	logic             at_last;

	assign advance = !valid_q || tx.ready;
	assign load    = advance && !qstat.empty;
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	assign tx.valid      = valid_q;
	assign tx.out_byte   = byte_q;
	assign tx.byte_valid = byte_valid_q;
	assign tx.run_last   = run_last_q;
	assign tx.text_end   = text_end_q;

	// Hold or refill the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= !qstat.empty;
			if (load) begin
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= head.has_data ? head.data[idx_q] : 8'h00;
			byte_valid_q <= head.has_data;
			run_last_q   <= at_last;
			text_end_q   <= at_last && head.text_end;
		end
	end

endmodule

// ===== sv/cp1252_to_utf8_stream.sv =====
// ----------------------------------------------------------------------------
// cp1252_to_utf8_stream
// Windows-1252 to UTF-8 transcoder with CRLF folding and NUL termination.
//
//   channel | dir | payload                                   | handshake
//   rx      | in  | in_byte[7:0], last_byte                   | valid/ready
//   tx      | out | out_byte[7:0], byte_valid, run_last, text_end | valid/ready
//
// An input word is taken every cycle while the four-group queue has room;
// each word becomes zero to four output words, sent one per cycle from the
// output register while tx is ready, so throughput is bound by the
// emitter's byte rate. The first output word of an input word is written
// to the queue and then to the output register, from which tx takes it.
// arst_n clears the CR/NUL state, the queue and the output valid.
// tx stalls back up through the queue to rx.ready independently.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cp1252_to_utf8_stream
	import c2u_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	c2u_in_if.sink    rx,
	c2u_out_if.source tx
);

	c2u_qstat_t qstat;
	c2u_entry_t push_entry;
	c2u_entry_t head;
	logic       push;
	logic       pop;

	// Classify and group
	c2u_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.qstat  (qstat),
		.push   (push),
		.entry  (push_entry)
	);

	// Decouple the two sides
	c2u_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// Emit bytes
	c2u_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.tx     (tx)
	);

	`ASSERT_ALWAYS(a_qcount_bound, clk, arst_n, qstat.count <= QCNT_W'(QDEPTH), "queue overflow")
	`ASSERT_IMPLIES(a_bare_marker, clk, arst_n, tx.valid && !tx.byte_valid, tx.run_last && tx.text_end, "bare marker without end flags")
	`ASSERT_IMPLIES(a_end_is_run_last, clk, arst_n, tx.valid && tx.text_end, tx.run_last, "text end not on run end")
	`ASSERT_IMPLIES(a_out_from_queue, clk, arst_n, $rose(tx.valid), $past(!qstat.empty), "output without queued group")

endmodule

// ===== tb/sv/tb_cp1252_to_utf8_stream.sv =====
// ----------------------------------------------------------------------------
// tb_cp1252_to_utf8_stream
// Self-checking bench for the Windows-1252 to UTF-8 transcoder. A clocked
// driver sends code page bytes from a pending queue. A behavioral transcoder
// predicts the UTF-8 words for every accepted byte, and the monitor checks
// them in order. The stimulus covers directed edge cases, random texts with
// CRLF pairs, NUL stops and high bytes, random gaps and stalls on both sides,
// one long output hold-off and several drain points.
// ----------------------------------------------------------------------------
module tb_cp1252_to_utf8_stream
	import c2u_pkg::*;
();

	localparam int RAND_ITEMS = 230;
	localparam int LONG_HOLD  = 120;
	localparam int CYCLE_CAP  = 400000;
	localparam int MAX_SHOWN  = 10;

	// One code page byte waiting to be sent, with its pacing controls
	typedef struct {
		logic [7:0] cbyte;
		logic       last;
		int         gap;
		bit         drain;
		bit         hold_rx;
		bit         calm;
	} cp_word_t;

	// One expected UTF-8 output word
	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       run_end;
		logic       text_end;
	} utf8_word_t;

	// Code points of bytes 0x80-0x9F; zero marks an unassigned slot
	localparam logic [15:0] CP_HI_TABLE [32] = '{
		16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
		16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
	};
	localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid  = 1'b0;
	logic [7:0] in_data   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_ready = 1'b0;

	c2u_in_if  rx_ch();
	c2u_out_if tx_ch();

	assign rx_ch.valid     = in_valid;
	assign rx_ch.in_byte   = in_data;
	assign rx_ch.last_byte = in_last;
	assign tx_ch.ready     = out_ready;

	cp1252_to_utf8_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	cp_word_t   text_q [$];
	utf8_word_t utf8_q [$];

	// Transcoder state mirrored by the predictor
	bit cr_pending = 1'b0;
	bit after_nul  = 1'b0;

	// Handshakes seen at the last rising edge
	bit rx_fire = 1'b0;
	bit tx_fire = 1'b0;

	// Driver state
	cp_word_t cur_word;
	bit       loaded  = 1'b0;
	bit       showing = 1'b0;
	int       gap_left = 0;
	bit       rx_calm  = 1'b0;
	int       hold_asked = 0;

	// Receiver state
	int hold_served = 0;
	int hold_left   = 0;
	int stall_left  = 0;
	bit ready_now   = 1'b0;

	// Run statistics
	int errors      = 0;
	int bytes_in    = 0;
	int words_out   = 0;
	int texts_ended = 0;
	int bare_marks  = 0;
	int cycles      = 0;

	always #1 clk = ~clk;

	function automatic utf8_word_t data_word(input logic [7:0] b);
		utf8_word_t w;
		w = '0;
		w.data     = b;
		w.has_data = 1'b1;
		return w;
	endfunction

	// Predict the UTF-8 words that one accepted byte yields
	function automatic void transcode(input logic [7:0] b, input logic last);
		utf8_word_t  grp [$];
		utf8_word_t  w;
		logic [15:0] cp;
		if (!after_nul) begin
			if (b == CHR_NUL) begin
				if (cr_pending) begin
					grp.insert(grp.size(), data_word(CHR_CR));
				end
				cr_pending = 1'b0;
				after_nul  = 1'b1;
			end else if (b == CHR_LF) begin
				// fold CRLF into LF: drop any held CR
				cr_pending = 1'b0;
				grp.insert(grp.size(), data_word(CHR_LF));
			end else if (b == CHR_CR) begin
				if (cr_pending) begin
					grp.insert(grp.size(), data_word(CHR_CR));
				end
				cr_pending = 1'b1;
			end else begin
				if (cr_pending) begin
					grp.insert(grp.size(), data_word(CHR_CR));
				end
				cr_pending = 1'b0;
				cp = {8'h00, b};
				if (b >= 8'h80 && b < 8'hA0) begin
					cp = CP_HI_TABLE[b[4:0]];
					if (cp == 16'h0000) begin
						cp = CP_REPLACEMENT;
					end
				end
				if (cp < 16'h0080) begin
					grp.insert(grp.size(), data_word(cp[7:0]));
				end else if (cp < 16'h0800) begin
					grp.insert(grp.size(), data_word({3'b110, cp[10:6]}));
					grp.insert(grp.size(), data_word({2'b10, cp[5:0]}));
				end else begin
					grp.insert(grp.size(), data_word({4'b1110, cp[15:12]}));
					grp.insert(grp.size(), data_word({2'b10, cp[11:6]}));
					grp.insert(grp.size(), data_word({2'b10, cp[5:0]}));
				end
			end
		end
		if (last) begin
			if (cr_pending) begin
				grp.insert(grp.size(), data_word(CHR_CR));
			end
			if (grp.size() == 0) begin
				w = '0;
				grp.insert(grp.size(), w);
			end
			grp[grp.size() - 1].text_end = 1'b1;
			cr_pending = 1'b0;
			after_nul  = 1'b0;
		end
		if (grp.size() != 0) begin
			grp[grp.size() - 1].run_end = 1'b1;
		end
		foreach (grp[i]) begin
			utf8_q.insert(utf8_q.size(), grp[i]);
		end
	endfunction

	task automatic log_error(input string msg);
		errors++;
		if (errors <= MAX_SHOWN) begin
			$display("[%0d] error: %s", cycles, msg);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last, input int gap,
			input bit drain, input bit hold_rx, input bit calm);
		cp_word_t w;
		w.cbyte   = b;
		w.last    = last;
		w.gap     = gap;
		w.drain   = drain;
		w.hold_rx = hold_rx;
		w.calm    = calm;
		text_q.insert(text_q.size(), w);
	endtask

	// Sample both channels; predict on input words, check output words
	always @(posedge clk) begin
		utf8_word_t exp_w;
		utf8_word_t got_w;
		if (!arst_n) begin
			rx_fire = 1'b0;
			tx_fire = 1'b0;
		end else begin
			rx_fire = rx_ch.valid && rx_ch.ready;
			tx_fire = tx_ch.valid && tx_ch.ready;
			if (rx_fire) begin
				bytes_in++;
				transcode(rx_ch.in_byte, rx_ch.last_byte);
			end
			if (tx_fire) begin
				got_w.data     = tx_ch.out_byte;
				got_w.has_data = tx_ch.byte_valid;
				got_w.run_end  = tx_ch.run_last;
				got_w.text_end = tx_ch.text_end;
				words_out++;
				if (utf8_q.size() == 0) begin
					log_error($sformatf("unexpected word byte=%h valid=%b run_last=%b end=%b",
						got_w.data, got_w.has_data, got_w.run_end, got_w.text_end));
				end else begin
					exp_w = utf8_q.pop_front();
					if (got_w.data !== exp_w.data || got_w.has_data !== exp_w.has_data ||
							got_w.run_end !== exp_w.run_end ||
							got_w.text_end !== exp_w.text_end) begin
						log_error($sformatf({"word %0d: exp byte=%h valid=%b run_last=%b end=%b,",
							" got byte=%h valid=%b run_last=%b end=%b"}, words_out,
							exp_w.data, exp_w.has_data, exp_w.run_end, exp_w.text_end,
							got_w.data, got_w.has_data, got_w.run_end, got_w.text_end));
					end
					if (exp_w.text_end) begin
						texts_ended++;
					end
					if (!exp_w.has_data) begin
						bare_marks++;
					end
				end
			end
		end
	end

	// Present pending words, honoring per-word gaps and drain points
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= 8'h00;
			in_last  <= 1'b0;
		end else begin
			if (showing && rx_fire) begin
				showing = 1'b0;
				loaded  = 1'b0;
			end
			if (!loaded && text_q.size() != 0) begin
				cur_word = text_q.pop_front();
				gap_left = cur_word.gap;
				loaded   = 1'b1;
			end
			if (loaded && !showing) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!cur_word.drain || utf8_q.size() == 0) begin
					showing = 1'b1;
					rx_calm = cur_word.calm;
					if (cur_word.hold_rx) begin
						hold_asked++;
					end
				end
			end
			in_valid <= showing;
			in_data  <= showing ? cur_word.cbyte : 8'($urandom);
			in_last  <= showing ? cur_word.last : 1'($urandom);
		end
	end

	// Stall the output side: a random wait per word, or a long hold on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (tx_fire) begin
				stall_left = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_now = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				ready_now = 1'b0;
			end else begin
				ready_now = 1'b1;
			end
			out_ready <= ready_now;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, utf8_q.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int         n_rand;
		int         text_no;
		int         len;
		int         r;
		bit         calm;
		logic [7:0] b;

		// Directed: extremes, table slots, CR handling, NUL stop, end markers
		queue_byte(8'h41, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h7F, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h80, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h81, 1'b0, 2, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h83, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h99, 1'b0, 5, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h9F, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hA0, 1'b0, 1, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_LF, 1'b0, 3, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h78, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_LF, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_NUL, 1'b0, 4, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h41, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hC5, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h5A, 1'b1, 0, 1'b1, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b1, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_NUL, 1'b1, 2, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h80, 1'b1, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(CHR_CR, 1'b0, 0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h99, 1'b1, 0, 1'b0, 1'b0, 1'b0);

		// Random texts, one burst behind a long output hold
		n_rand  = 0;
		text_no = 0;
		while (n_rand < RAND_ITEMS) begin
			if (text_no == 4) begin
				for (int k = 0; k < 30; k++) begin
					b = 8'($urandom_range(8'h80, 8'hFF));
					queue_byte(b, k == 29, 0, 1'b0, k == 0, 1'b0);
					n_rand++;
				end
			end else begin
				len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
				calm = (text_no % 6 == 3);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 40) begin
						b = 8'($urandom_range(8'h20, 8'h7E));
					end else if (r < 52) begin
						b = 8'($urandom_range(8'h80, 8'h9F));
					end else if (r < 66) begin
						b = 8'($urandom_range(8'hA0, 8'hFF));
					end else if (r < 76) begin
						b = CHR_CR;
					end else if (r < 82) begin
						b = CHR_LF;
					end else if (r < 85) begin
						b = CHR_NUL;
					end else if (r < 90) begin
						b = 8'($urandom_range(1, 8'h1F));
					end else begin
						b = 8'($urandom);
					end
					queue_byte(b, k == len - 1, calm ? 0 : $urandom_range(0, 10),
						k == 0 && text_no % 5 == 1, 1'b0, calm);
					n_rand++;
					// often follow a CR with LF to exercise folding
					if (b == CHR_CR && k < len - 1 && $urandom_range(0, 1) == 1) begin
						k++;
						queue_byte(CHR_LF, k == len - 1, calm ? 0 : $urandom_range(0, 10),
							1'b0, 1'b0, calm);
						n_rand++;
					end
				end
			end
			text_no++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for all words to be sent and all results to arrive
		while (text_q.size() != 0 || loaded || utf8_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (utf8_q.size() != 0) begin
			log_error($sformatf("%0d expected words never arrived", utf8_q.size()));
		end

		$display("sent %0d code page bytes in %0d texts, checked %0d UTF-8 words",
			bytes_in, texts_ended, words_out);
		$display("%0d bare end markers, %0d mismatches", bare_marks, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
